@@ src/cds_pkg.sv @@
// ----------------------------------------------------------------------------
// cds_pkg: shared types and constants of the conveyor device sequencer
// Register map, phase codes and the per-conveyor state record.
// ----------------------------------------------------------------------------
`default_nettype none

package cds_pkg;

  // Plan register layout
  localparam int unsigned PLAN_W     = 37;
  localparam int unsigned ON_TIME_W  = 10;
  localparam int unsigned PAUSE_W    = 7;
  localparam int unsigned PAUSE_LSB  = 30;
  localparam int unsigned SCALE_W    = 10;
  localparam int unsigned NUM_PLANS  = 4;
  localparam int unsigned NUM_DEV    = 3;

  // Configuration port
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = PLAN_W;
  localparam logic [CFG_IDX_W-1:0] REG_PLAN_CONVEYOR0 = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TIME_SCALE     = 3'd4;
  localparam logic [SCALE_W-1:0]   SCALE_RESET        = 10'd1;

  // Time base
  localparam int unsigned TIME_W = 32;

  // Payload widths
  localparam int unsigned CONV_W  = 2;
  localparam int unsigned PHASE_W = 3;

  // Sequence phases
  localparam logic [PHASE_W-1:0] PH_START     = 3'd0;
  localparam logic [PHASE_W-1:0] PH_DEV0_ON   = 3'd1;
  localparam logic [PHASE_W-1:0] PH_PAUSE0    = 3'd2;
  localparam logic [PHASE_W-1:0] PH_DEV1_ON   = 3'd3;
  localparam logic [PHASE_W-1:0] PH_PAUSE1    = 3'd4;
  localparam logic [PHASE_W-1:0] PH_DEV2_ON   = 3'd5;
  localparam logic [PHASE_W-1:0] PH_FINAL     = 3'd6;

  typedef logic [PLAN_W-1:0] plan_t;

  typedef struct packed {
    logic [TIME_W-1:0]  deadline;
    logic [PHASE_W-1:0] phase;
    logic [NUM_DEV-1:0] drive;
  } conv_state_t;

endpackage

`default_nettype wire

@@ src/cds_cfg_regs.sv @@
// ----------------------------------------------------------------------------
// cds_cfg_regs: configuration register file
// Holds the four conveyor plans and the common time scale.
// ----------------------------------------------------------------------------
`default_nettype none

module cds_cfg_regs (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             cfg_we_i,
  input  wire logic [cds_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  wire logic [cds_pkg::CFG_DATA_W-1:0]   cfg_wdata_i,
  output      cds_pkg::plan_t                   plan_o [cds_pkg::NUM_PLANS],
  output      logic [cds_pkg::SCALE_W-1:0]      scale_o
);

  cds_pkg::plan_t                plan_q [cds_pkg::NUM_PLANS];
  logic [cds_pkg::SCALE_W-1:0]   scale_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < int'(cds_pkg::NUM_PLANS); i++) begin
        plan_q[i] <= '0;
      end
      scale_q <= cds_pkg::SCALE_RESET;
    end else if (cfg_we_i) begin
      if (cfg_idx_i < cds_pkg::REG_TIME_SCALE) begin
        plan_q[cfg_idx_i[1:0]] <= cfg_wdata_i[cds_pkg::PLAN_W-1:0];
      end else if (cfg_idx_i == cds_pkg::REG_TIME_SCALE) begin
        scale_q <= cfg_wdata_i[cds_pkg::SCALE_W-1:0];
      end
    end
  end

  assign plan_o  = plan_q;
  assign scale_o = scale_q;

endmodule

`default_nettype wire

@@ src/cds_step.sv @@
// ----------------------------------------------------------------------------
// cds_step: next-state logic of one conveyor
// Expiry test, deadline arming and phase/drive update for one poll.
// ----------------------------------------------------------------------------
`default_nettype none

module cds_step (
  input  wire logic                           run_i,
  input  wire logic [cds_pkg::TIME_W-1:0]     now_i,
  input  wire cds_pkg::plan_t                 plan_i,
  input  wire logic [cds_pkg::SCALE_W-1:0]    scale_i,
  input  wire cds_pkg::conv_state_t           cur_i,
  output      cds_pkg::conv_state_t           nxt_o
);

  logic [cds_pkg::ON_TIME_W-1:0]            units;
  logic [cds_pkg::ON_TIME_W+cds_pkg::SCALE_W-1:0] span;
  logic [cds_pkg::TIME_W-1:0]               armed;
  logic [cds_pkg::TIME_W-1:0]               age;
  logic                                     expired;
  logic [cds_pkg::NUM_DEV-1:0]              dev_bit;

  // Pick the time slot for the deadline armed from this phase.
  always_comb begin
    case (cur_i.phase)
      cds_pkg::PH_PAUSE0: units = plan_i[19:10];
      cds_pkg::PH_PAUSE1: units = plan_i[29:20];
      cds_pkg::PH_DEV0_ON,
      cds_pkg::PH_DEV1_ON,
      cds_pkg::PH_DEV2_ON:
        units = {{(cds_pkg::ON_TIME_W-cds_pkg::PAUSE_W){1'b0}},
                 plan_i[cds_pkg::PAUSE_LSB +: cds_pkg::PAUSE_W]};
      default:            units = plan_i[9:0];
    endcase
  end

  assign span    = units * scale_i;
  assign armed   = now_i + cds_pkg::TIME_W'(span);
  assign age     = now_i - cur_i.deadline;
  assign expired = ~age[cds_pkg::TIME_W-1];
  // Device touched by phases 1..5 sits at phase / 2.
  assign dev_bit = cds_pkg::NUM_DEV'(1) << cur_i.phase[2:1];

  always_comb begin
    nxt_o = cur_i;
    if (!run_i) begin
      nxt_o.drive = '0;
      nxt_o.phase = cds_pkg::PH_START;
    end else begin
      case (cur_i.phase)
        cds_pkg::PH_START: begin
          nxt_o.deadline = armed;
          nxt_o.drive    = cur_i.drive | cds_pkg::NUM_DEV'(1);
          nxt_o.phase    = cds_pkg::PH_DEV0_ON;
        end
        cds_pkg::PH_DEV0_ON,
        cds_pkg::PH_DEV1_ON,
        cds_pkg::PH_DEV2_ON: begin
          if (expired) begin
            nxt_o.deadline = armed;
            nxt_o.drive    = cur_i.drive & ~dev_bit;
            nxt_o.phase    = cur_i.phase + cds_pkg::PHASE_W'(1);
          end
        end
        cds_pkg::PH_PAUSE0,
        cds_pkg::PH_PAUSE1: begin
          if (expired) begin
            nxt_o.deadline = armed;
            nxt_o.drive    = cur_i.drive | dev_bit;
            nxt_o.phase    = cur_i.phase + cds_pkg::PHASE_W'(1);
          end
        end
        cds_pkg::PH_FINAL: begin
          if (expired) begin
            nxt_o.phase = cds_pkg::PH_START;
          end
        end
        default: nxt_o = cur_i;
      endcase
    end
  end

endmodule

`default_nettype wire

@@ src/conveyor_device_sequencer.sv @@
// ----------------------------------------------------------------------------
// conveyor_device_sequencer: four-conveyor, three-device timed sequencer
// Keeps a millisecond counter and, per conveyor, a seven-phase on/pause
// sequence driving three devices; each poll returns that conveyor's drive.
// ----------------------------------------------------------------------------
//
//   Channel  Direction  Handshake                 Payload
//   -------  ---------  ------------------------  -------------------------------
//   in       sink       in_valid_i / in_ready_o   conveyor_i, run_i, tick_i
//   out      source     out_valid_o / out_ready_i conveyor_echo_o, device_mask_o,
//                                                 phase_out_o
//   cfg      sink       cfg_we_i (no wait)        cfg_idx_i, cfg_wdata_i
//
// Cycles: one transaction per cycle while the output is not stalled; a result passes
//   through the input register, then the result register, before it is offered.
// The per-conveyor state update (expiry compare, 10x10 multiply, 32-bit add)
//   completes in the cycle the poll moves into the result register, so the
//   next poll of the same conveyor sees the updated state.
// Reset: counter, deadlines, phases and drives go to zero, time scale to one.
// Stalls: the input register keeps accepting while the result register is
//   free or being drained; a stalled output holds its result.
`default_nettype none

module conveyor_device_sequencer #(
  parameter int unsigned NUM_CONVEYORS = 4
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  // Poll transactions
  input  wire logic                            in_valid_i,
  output      logic                            in_ready_o,
  input  wire logic [cds_pkg::CONV_W-1:0]      conveyor_i,
  input  wire logic                            run_i,
  input  wire logic                            tick_i,
  // Result transactions
  output      logic                            out_valid_o,
  input  wire logic                            out_ready_i,
  output      logic [cds_pkg::CONV_W-1:0]      conveyor_echo_o,
  output      logic [cds_pkg::NUM_DEV-1:0]     device_mask_o,
  output      logic [cds_pkg::PHASE_W-1:0]     phase_out_o,
  // Configuration writes
  input  wire logic                            cfg_we_i,
  input  wire logic [cds_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  wire logic [cds_pkg::CFG_DATA_W-1:0]  cfg_wdata_i
);

  // Only conveyors that have a plan register carry state.
  localparam int unsigned NCONV  = (NUM_CONVEYORS < cds_pkg::NUM_PLANS) ?
                                   NUM_CONVEYORS : cds_pkg::NUM_PLANS;
  localparam int unsigned CIDX_W = (NCONV > 1) ? $clog2(NCONV) : 1;

  // Configuration
  cds_pkg::plan_t                plan   [cds_pkg::NUM_PLANS];
  logic [cds_pkg::SCALE_W-1:0]   scale;

  cds_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i),
    .plan_o     (plan),
    .scale_o    (scale)
  );

  // Input register
  logic                          in_vld_q;
  logic [cds_pkg::CONV_W-1:0]    in_conv_q;
  logic                          in_run_q;
  logic                          in_tick_q;

  // Result register
  logic                          out_vld_q;
  logic [cds_pkg::CONV_W-1:0]    out_conv_q;
  logic [cds_pkg::NUM_DEV-1:0]   out_mask_q;
  logic [cds_pkg::PHASE_W-1:0]   out_phase_q;

  // Sequencer state
  logic [cds_pkg::TIME_W-1:0]    time_now_q;
  logic [cds_pkg::TIME_W-1:0]    time_now_d;
  cds_pkg::conv_state_t          conv_q [NCONV];

  logic                          advance;
  logic                          in_range;
  logic [CIDX_W-1:0]             sel;
  cds_pkg::conv_state_t          cur;
  cds_pkg::conv_state_t          nxt;

  // Move the held poll into the result register when that slot frees up.
  assign advance    = in_vld_q && (!out_vld_q || out_ready_i);
  assign in_ready_o = !in_vld_q || advance;

  assign in_range   = ({1'b0, in_conv_q} < (cds_pkg::CONV_W+1)'(NCONV));
  assign sel        = CIDX_W'(in_conv_q);
  assign cur        = in_range ? conv_q[sel] : '0;

  // Tick applies before the poll is evaluated.
  assign time_now_d = time_now_q + cds_pkg::TIME_W'(in_tick_q);

  cds_step u_step (
    .run_i  (in_run_q),
    .now_i  (time_now_d),
    .plan_i (plan[in_conv_q]),
    .scale_i(scale),
    .cur_i  (cur),
    .nxt_o  (nxt)
  );

  // Input register control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_ready_o) begin
      in_vld_q <= in_valid_i;
    end
  end

  // Input register payload
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_conv_q <= conveyor_i;
      in_run_q  <= run_i;
      in_tick_q <= tick_i;
    end
  end

  // Result register control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (advance) begin
      out_vld_q <= 1'b1;
    end else if (out_ready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  // Result register payload; out-of-range polls report a zero mask and phase.
  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_conv_q  <= in_conv_q;
      out_mask_q  <= in_range ? nxt.drive : '0;
      out_phase_q <= in_range ? nxt.phase : cds_pkg::PH_START;
    end
  end

  // Advance time and commit the polled conveyor's new state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      time_now_q <= '0;
      for (int i = 0; i < int'(NCONV); i++) begin
        conv_q[i] <= '0;
      end
    end else if (advance) begin
      time_now_q <= time_now_d;
      for (int i = 0; i < int'(NCONV); i++) begin
        if (in_range && (sel == CIDX_W'(i))) begin
          conv_q[i] <= nxt;
        end
      end
    end
  end

  assign out_valid_o     = out_vld_q;
  assign conveyor_echo_o = out_conv_q;
  assign device_mask_o   = out_mask_q;
  assign phase_out_o     = out_phase_q;

endmodule

`default_nettype wire
